>>> rtl/expadsr_pkg.sv
// ----------------------------------------------------------------------------
// expadsr_pkg
// Shared types and codes for the exponential ADSR envelope block.
// ----------------------------------------------------------------------------
package expadsr_pkg;

  // Envelope phases as they appear on the result channel.
  localparam logic [2:0] PH_OFF     = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  // Item kinds.
  localparam logic [1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_ATTACK  = 32'd1074022178;
  localparam logic [31:0] RST_DECAY   = 32'd0;
  localparam logic [31:0] RST_RELEASE = 32'd1073741824;
  localparam logic [30:0] RST_SUSTAIN = 31'd10737;
  localparam logic [30:0] RST_FLOOR   = 31'd10737;

  typedef struct packed {
    logic [31:0] attack_factor;
    logic [31:0] decay_factor;
    logic [31:0] release_factor;
    logic [30:0] sustain_gain;
    logic [30:0] floor_gain;
  } cfg_t;

  // Envelope state: phase, gain and per-sample step factor.
  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] gain;
    logic [31:0] factor;
  } env_t;

endpackage

>>> rtl/expadsr_cfg.sv
// ----------------------------------------------------------------------------
// expadsr_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module expadsr_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [expadsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [expadsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output expadsr_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_factor  <= expadsr_pkg::RST_ATTACK;
      cfg.decay_factor   <= expadsr_pkg::RST_DECAY;
      cfg.release_factor <= expadsr_pkg::RST_RELEASE;
      cfg.sustain_gain   <= expadsr_pkg::RST_SUSTAIN;
      cfg.floor_gain     <= expadsr_pkg::RST_FLOOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        expadsr_pkg::REG_ATTACK:  cfg.attack_factor  <= cfg_wdata;
        expadsr_pkg::REG_DECAY:   cfg.decay_factor   <= cfg_wdata;
        expadsr_pkg::REG_RELEASE: cfg.release_factor <= cfg_wdata;
        expadsr_pkg::REG_SUSTAIN: cfg.sustain_gain   <= cfg_wdata[30:0];
        expadsr_pkg::REG_FLOOR:   cfg.floor_gain     <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/expadsr_mul.sv
// ----------------------------------------------------------------------------
// expadsr_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module expadsr_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= 64'(a) * 64'(b);
    end
  end

endmodule

>>> rtl/expadsr_core.sv
// ----------------------------------------------------------------------------
// expadsr_core
// Envelope sequencer: phase transitions, gain update and sample scaling,
// both multiplies going through one shared multiplier.
// ----------------------------------------------------------------------------
module expadsr_core #(
  parameter int unsigned GAIN_FRAC_BITS = 30,
  parameter int unsigned SAMPLE_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  expadsr_pkg::cfg_t              cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic [2:0]                     phase,
  output logic                           is_off,
  output logic                           mul_en,
  output logic [31:0]                    mul_a,
  output logic [31:0]                    mul_b,
  input  logic [63:0]                    mul_p
);

  localparam logic [31:0] UNITY = 32'd1 << GAIN_FRAC_BITS;
  localparam logic [63:0] SBIT  = 64'd1 << (SAMPLE_WIDTH - 1);
  localparam logic [63:0] SMAX  = SBIT - 64'd1;
  localparam logic [63:0] FMASK = (64'd1 << GAIN_FRAC_BITS) - 64'd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MG   = 3'd2;
  localparam logic [2:0] S_UG   = 3'd3;
  localparam logic [2:0] S_MS   = 3'd4;
  localparam logic [2:0] S_SC   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]              state;
  logic [1:0]              mode_q;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic [SAMPLE_WIDTH-1:0] y;
  expadsr_pkg::env_t       env;

  expadsr_pkg::env_t       env_a;
  expadsr_pkg::env_t       env_d;
  expadsr_pkg::env_t       env_r;
  expadsr_pkg::env_t       env_next;
  logic                    ended;
  logic                    neg;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [63:0]             q_s;
  logic                    frac_nz;
  logic [63:0]             r_neg;
  logic [63:0]             y_neg;
  logic [SAMPLE_WIDTH-1:0] y_next;
  logic [31:0]             gain_sat;

  // Entering a phase; a zero factor falls through to the next phase.
  function automatic expadsr_pkg::env_t enter(input logic [2:0] p_in,
                                              input expadsr_pkg::env_t cur,
                                              input expadsr_pkg::cfg_t c);
    expadsr_pkg::env_t r;
    logic [2:0]        p;
    r = cur;
    p = p_in;
    if (p == expadsr_pkg::PH_ATTACK && c.attack_factor == 32'd0) p = expadsr_pkg::PH_DECAY;
    if (p == expadsr_pkg::PH_DECAY && c.decay_factor == 32'd0) p = expadsr_pkg::PH_SUSTAIN;
    if (p == expadsr_pkg::PH_RELEASE && c.release_factor == 32'd0) p = expadsr_pkg::PH_OFF;
    r.phase = p;
    case (p)
      expadsr_pkg::PH_OFF: begin
        r.gain = 32'd0;
      end
      expadsr_pkg::PH_ATTACK: begin
        r.gain   = {1'b0, c.floor_gain};
        r.factor = c.attack_factor;
      end
      expadsr_pkg::PH_DECAY: begin
        r.gain   = UNITY;
        r.factor = c.decay_factor;
      end
      expadsr_pkg::PH_SUSTAIN: begin
        r.gain   = {1'b0, c.sustain_gain};
        r.factor = UNITY;
      end
      default: begin
        r.factor = c.release_factor;
      end
    endcase
    return r;
  endfunction

  // Segment end checks, applied in order on the current gain.
  always_comb begin
    env_a = (env.phase == expadsr_pkg::PH_ATTACK && env.gain >= UNITY)
          ? enter(expadsr_pkg::PH_DECAY, env, cfg) : env;
    env_d = (env_a.phase == expadsr_pkg::PH_DECAY && env_a.gain < {1'b0, cfg.sustain_gain})
          ? enter(expadsr_pkg::PH_SUSTAIN, env_a, cfg) : env_a;
    ended = env_d.phase == expadsr_pkg::PH_RELEASE && env_d.gain < {1'b0, cfg.floor_gain};
    env_r = ended ? enter(expadsr_pkg::PH_OFF, env_d, cfg) : env_d;
    case (mode_q)
      expadsr_pkg::MODE_SAMPLE:   env_next = env_r;
      expadsr_pkg::MODE_NOTE_ON:  env_next = enter(expadsr_pkg::PH_ATTACK, env, cfg);
      expadsr_pkg::MODE_NOTE_OFF: env_next = enter(expadsr_pkg::PH_RELEASE, env, cfg);
      default:                    env_next = env;
    endcase
  end

  // Sample magnitude; the most negative sample maps to its exact magnitude.
  assign neg = sample_q[SAMPLE_WIDTH-1];
  assign mag = neg ? (~sample_q + 1'b1) : sample_q;

  // The same multiplier forms gain*factor first, then magnitude*gain.
  assign mul_en = (state == S_MG) || (state == S_MS);
  assign mul_a  = env.gain;
  assign mul_b  = (state == S_MG) ? env.factor : 32'(mag);

  always_comb begin
    q_s      = mul_p >> GAIN_FRAC_BITS;
    frac_nz  = |(mul_p & FMASK);
    gain_sat = (|q_s[63:32]) ? 32'hFFFF_FFFF : q_s[31:0];
    r_neg    = q_s + 64'(frac_nz);
    if (r_neg > SBIT) r_neg = SBIT;
    y_neg    = 64'd0 - r_neg;
    if (neg) begin
      y_next = y_neg[SAMPLE_WIDTH-1:0];
    end else if (q_s > SMAX) begin
      y_next = SMAX[SAMPLE_WIDTH-1:0];
    end else begin
      y_next = q_s[SAMPLE_WIDTH-1:0];
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      env.phase  <= expadsr_pkg::PH_OFF;
      env.gain   <= 32'd0;
      env.factor <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      // In the final state the output register is loaded below instead.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q   <= mode;
            sample_q <= sample_in;
            state    <= S_CHK;
          end
        end
        S_CHK: begin
          env <= env_next;
          y   <= '0;
          if (mode_q == expadsr_pkg::MODE_SAMPLE && !ended) begin
            state <= S_MG;
          end else begin
            state <= S_DONE;
          end
        end
        S_MG: begin
          state <= S_UG;
        end
        S_UG: begin
          env.gain <= gain_sat;
          state    <= S_MS;
        end
        S_MS: begin
          state <= S_SC;
        end
        S_SC: begin
          y     <= y_next;
          state <= S_DONE;
        end
        S_DONE: begin
          // The output register may still hold an earlier transaction.
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            sample_out <= $signed(y);
            phase      <= env.phase;
            is_off     <= (env.phase == expadsr_pkg::PH_OFF);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/exponential_adsr_envelope_top.sv
// ----------------------------------------------------------------------------
// exponential_adsr_envelope_top
// Exponential ADSR envelope: gain stepped by a per-segment Q2.30 factor on
// every audio sample, and the sample scaled by the gain.
// ----------------------------------------------------------------------------
// Sequencing: note events, unused-mode items and a sample that ends the release
// go from the check state straight to the result; other audio samples pass
// twice through the shared multiplier first. One item is taken at a time: the
// next is accepted only after the last result is loaded into the output register.
// Reset: synchronous; configuration returns to defaults, phase to off, gain 0.
// ----------------------------------------------------------------------------
module exponential_adsr_envelope_top #(
  parameter int unsigned GAIN_FRAC_BITS = 30,
  parameter int unsigned SAMPLE_WIDTH   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [expadsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [expadsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic [2:0]                           phase,
  output logic                                 is_off
);

  expadsr_pkg::cfg_t cfg;
  logic              mul_en;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;

  expadsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  expadsr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  expadsr_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .phase      (phase),
    .is_off     (is_off),
    .mul_en     (mul_en),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p)
  );

endmodule

>>> rtl/expadsr_checker.sv
// ----------------------------------------------------------------------------
// expadsr_checker
// Port-level checks on the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module expadsr_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out,
  input logic [2:0]              phase,
  input logic                    is_off
);

  // The off flag agrees with the reported phase whenever a result is valid.
  a_off_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_off == (phase == expadsr_pkg::PH_OFF)))
    else $error("is_off disagrees with phase");

  // With the envelope off the gain is zero, so the output is silent.
  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == expadsr_pkg::PH_OFF) |-> (sample_out == '0))
    else $error("nonzero output in off phase");

  // One item at a time: the block is busy right after taking a transaction.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(phase)))
    else $error("stalled result changed");

endmodule

bind exponential_adsr_envelope_top expadsr_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_expadsr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .phase      (phase),
  .is_off     (is_off)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exponential ADSR envelope. A behavioral copy of
// the envelope (phase, gain and step factor) predicts every output
// transaction. The bench drives short directed note sequences, then long
// random ones under several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned SAMPLE_W  = 24;
  localparam logic [31:0] UNITY     = 32'h4000_0000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [2:0]                 phase;
    logic                       is_off;
  } envelope_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_wr_en = 1'b0;
  logic [expadsr_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [expadsr_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic [1:0]                            mode = expadsr_pkg::MODE_SAMPLE;
  logic signed [SAMPLE_W-1:0]            sample_in = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]            sample_out;
  logic [2:0]                            phase;
  logic                                  is_off;

  // Predicted register contents and envelope state.
  logic [31:0] attack_cfg  = expadsr_pkg::RST_ATTACK;
  logic [31:0] decay_cfg   = expadsr_pkg::RST_DECAY;
  logic [31:0] release_cfg = expadsr_pkg::RST_RELEASE;
  logic [30:0] sustain_cfg = expadsr_pkg::RST_SUSTAIN;
  logic [30:0] floor_cfg   = expadsr_pkg::RST_FLOOR;
  logic [2:0]  env_phase   = expadsr_pkg::PH_OFF;
  logic [31:0] env_gain    = '0;
  logic [31:0] env_factor  = '0;

  envelope_result_t expected_outputs[$];

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned samples_sent = 0;
  int unsigned note_ons = 0;
  int unsigned note_offs = 0;
  int unsigned unused_sent = 0;
  int unsigned settings_used = 0;

  exponential_adsr_envelope_top #(
    .GAIN_FRAC_BITS(FRAC_BITS),
    .SAMPLE_WIDTH  (SAMPLE_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .phase     (phase),
    .is_off    (is_off)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t timeout with %0d results outstanding", $time, expected_outputs.size());
    $display("exponential_adsr_envelope_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Segment entry, including the fall-through of segments whose factor is zero.
  function automatic void enter_segment(input logic [2:0] target);
    logic [2:0] p;
    p = target;
    if (p == expadsr_pkg::PH_ATTACK && attack_cfg == 0) p = expadsr_pkg::PH_DECAY;
    if (p == expadsr_pkg::PH_DECAY && decay_cfg == 0) p = expadsr_pkg::PH_SUSTAIN;
    if (p == expadsr_pkg::PH_RELEASE && release_cfg == 0) p = expadsr_pkg::PH_OFF;
    env_phase = p;
    case (p)
      expadsr_pkg::PH_OFF: env_gain = '0;
      expadsr_pkg::PH_ATTACK: begin
        env_gain   = {1'b0, floor_cfg};
        env_factor = attack_cfg;
      end
      expadsr_pkg::PH_DECAY: begin
        env_gain   = UNITY;
        env_factor = decay_cfg;
      end
      expadsr_pkg::PH_SUSTAIN: begin
        env_gain   = {1'b0, sustain_cfg};
        env_factor = UNITY;
      end
      default: env_factor = release_cfg;
    endcase
  endfunction

  function automatic envelope_result_t step_envelope(input logic [1:0] m,
                                                     input logic signed [SAMPLE_W-1:0] s);
    envelope_result_t r;
    logic [63:0]      g;
    longint           prod;
    longint           y;
    logic             ended;
    r.sample = '0;
    ended = 1'b0;
    case (m)
      expadsr_pkg::MODE_NOTE_ON:  enter_segment(expadsr_pkg::PH_ATTACK);
      expadsr_pkg::MODE_NOTE_OFF: enter_segment(expadsr_pkg::PH_RELEASE);
      expadsr_pkg::MODE_SAMPLE: begin
        if (env_phase == expadsr_pkg::PH_ATTACK && env_gain >= UNITY)
          enter_segment(expadsr_pkg::PH_DECAY);
        if (env_phase == expadsr_pkg::PH_DECAY && env_gain < {1'b0, sustain_cfg})
          enter_segment(expadsr_pkg::PH_SUSTAIN);
        if (env_phase == expadsr_pkg::PH_RELEASE && env_gain < {1'b0, floor_cfg}) begin
          enter_segment(expadsr_pkg::PH_OFF);
          ended = 1'b1;
        end
        if (!ended) begin
          g = ({32'd0, env_gain} * {32'd0, env_factor}) >> FRAC_BITS;
          env_gain = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
          // An arithmetic shift of the signed product rounds toward minus infinity.
          prod = longint'(s) * longint'({32'd0, env_gain});
          y = prod >>> FRAC_BITS;
          if (y > 8388607) r.sample = 24'h7F_FFFF;
          else if (y < -8388608) r.sample = 24'h80_0000;
          else r.sample = y[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
    r.phase  = env_phase;
    r.is_off = (env_phase == expadsr_pkg::PH_OFF);
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    envelope_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t ERROR unexpected transaction: sample_out %0d phase %0d is_off %0d",
                 $time, sample_out, phase, is_off);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (sample_out !== want.sample) begin
          $display("%0t ERROR sample_out expected %0d actual %0d",
                   $time, want.sample, sample_out);
          errors++;
        end
        if (phase !== want.phase) begin
          $display("%0t ERROR phase expected %0d actual %0d", $time, want.phase, phase);
          errors++;
        end
        if (is_off !== want.is_off) begin
          $display("%0t ERROR is_off expected %0d actual %0d", $time, want.is_off, is_off);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    expected_outputs.push_back(step_envelope(m, s));
    items_sent++;
    case (m)
      expadsr_pkg::MODE_SAMPLE:   samples_sent++;
      expadsr_pkg::MODE_NOTE_ON:  note_ons++;
      expadsr_pkg::MODE_NOTE_OFF: note_offs++;
      default:                    unused_sent++;
    endcase
  endtask

  // Holds off the sender until every expected transaction has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [expadsr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      expadsr_pkg::REG_ATTACK:  attack_cfg  = data;
      expadsr_pkg::REG_DECAY:   decay_cfg   = data;
      expadsr_pkg::REG_RELEASE: release_cfg = data;
      expadsr_pkg::REG_SUSTAIN: sustain_cfg = data[30:0];
      expadsr_pkg::REG_FLOOR:   floor_cfg   = data[30:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] atk, input logic [31:0] dec,
                           input logic [31:0] rel, input logic [31:0] sus,
                           input logic [31:0] flr);
    write_register(expadsr_pkg::REG_ATTACK, atk);
    write_register(expadsr_pkg::REG_DECAY, dec);
    write_register(expadsr_pkg::REG_RELEASE, rel);
    write_register(expadsr_pkg::REG_SUSTAIN, sus);
    write_register(expadsr_pkg::REG_FLOOR, flr);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(15))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'h00_0000;
      3: return 24'hFF_FFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(2))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return UNITY;
    endcase
  endfunction

  // Power-on register values: a slow attack from the floor and a release that holds.
  task automatic test_reset_defaults();
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h12_3456);
    send_item(expadsr_pkg::MODE_NOTE_ON, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h7F_FFFF);
    send_item(expadsr_pkg::MODE_NOTE_OFF, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h80_0000);
    wait_idle();
  endtask

  // Largest factors and levels drive the gain and the output into saturation.
  task automatic test_saturation();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, UNITY);
    send_item(expadsr_pkg::MODE_NOTE_ON, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h7F_FFFF);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h80_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'hFF_FFFF);
    send_item(expadsr_pkg::MODE_NOTE_OFF, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h7F_FFFF);
    wait_idle();
  endtask

  // Zero factors skip attack and decay on note-on and release on note-off.
  task automatic test_segment_skips();
    configure(32'h0, 32'h0, 32'h0, UNITY >> 1, 32'd1000);
    send_item(expadsr_pkg::MODE_NOTE_ON, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h40_0000);
    send_item(MODE_UNUSED, 24'h7F_FFFF);
    send_item(expadsr_pkg::MODE_NOTE_OFF, 24'h00_0000);
    send_item(expadsr_pkg::MODE_SAMPLE, 24'h40_0000);
    wait_idle();
  endtask

  // Power-of-two factors walk each threshold exactly: attack reaches unity, decay
  // drops below sustain, and release falls under the floor and turns off.
  task automatic test_segment_ends();
    configure(UNITY << 1, UNITY >> 1, UNITY >> 1, (UNITY >> 2) + 1, UNITY >> 3);
    send_item(expadsr_pkg::MODE_NOTE_ON, 24'h00_0000);
    repeat (3) begin
      send_item(expadsr_pkg::MODE_SAMPLE, 24'h7F_FFFF);
      send_item(expadsr_pkg::MODE_SAMPLE, 24'h80_0001);
    end
    send_item(expadsr_pkg::MODE_NOTE_OFF, 24'h00_0000);
    repeat (3) send_item(expadsr_pkg::MODE_SAMPLE, 24'h55_5555);
    wait_idle();
  endtask

  task automatic pick_setting();
    logic [31:0] atk, dec, rel, sus, flr;
    case ($urandom_range(5))
      0: begin
        atk = $urandom;
        dec = $urandom;
        rel = $urandom;
        sus = $urandom;
        flr = $urandom;
      end
      1: begin
        atk = extreme_value();
        dec = extreme_value();
        rel = extreme_value();
        sus = extreme_value();
        flr = extreme_value();
      end
      default: begin
        // Attack factors above unity, decay and release factors below it, now and then zero.
        atk = ($urandom_range(7) == 0) ? 32'h0 : UNITY + $urandom_range(UNITY >> 1, UNITY << 1);
        dec = ($urandom_range(7) == 0) ? 32'h0 : $urandom_range(UNITY >> 1, UNITY - (UNITY >> 4));
        rel = ($urandom_range(7) == 0) ? 32'h0 : $urandom_range(UNITY >> 1, UNITY - (UNITY >> 4));
        sus = $urandom_range(0, UNITY);
        flr = $urandom_range(1 << 12, 1 << 24);
      end
    endcase
    wait_idle();
    configure(atk, dec, rel, sus, flr);
  endtask

  task automatic send_sample_or_noise();
    if ($urandom_range(24) == 0) send_item(2'($urandom_range(3)), random_sample());
    else send_item(expadsr_pkg::MODE_SAMPLE, random_sample());
  endtask

  task automatic play_note();
    send_item(expadsr_pkg::MODE_NOTE_ON, random_sample());
    repeat ($urandom_range(1, 64)) send_sample_or_noise();
    // Now and then the next note retriggers without a note-off.
    if ($urandom_range(7) != 0) begin
      send_item(expadsr_pkg::MODE_NOTE_OFF, random_sample());
      repeat ($urandom_range(1, 48)) send_sample_or_noise();
    end
  endtask

  task automatic run_random_phase(input int unsigned tx_idle, input int unsigned rx_idle,
                                  input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    send_idle = tx_idle;
    recv_idle = rx_idle;
    while (items_sent < stop_at) begin
      pick_setting();
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < stop_at) play_note();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    send_idle = 37;
    recv_idle = 76;
    test_reset_defaults();
    test_saturation();
    test_segment_skips();
    test_segment_ends();
    run_random_phase(37, 76, 480);
    run_random_phase(76, 37, 480);
    run_random_phase(0, 0, 480);
    wait_idle();
    $display("Covered %0d samples, %0d note-ons, %0d note-offs and %0d unused-mode items",
             samples_sent, note_ons, note_offs, unused_sent);
    $display("across %0d register settings; %0d output transactions compared.",
             settings_used, results_checked);
    if (errors == 0) begin
      $display("exponential_adsr_envelope_top verification clean");
    end else begin
      $display("exponential_adsr_envelope_top verification failed");
    end
    $finish;
  end

endmodule
